/* hw/rtl/icr_pkg.sv */
package icr_pkg;

  // Result status carried with every resolved pair.
  typedef enum logic [1:0] {
    OC_APPLIED    = 2'd0,
    OC_SEPARATING = 2'd1,
    OC_DEGENERATE = 2'd2
  } outcome_t;

  localparam int OUTCOME_BITS = 2;

endpackage

/* hw/rtl/icr_div.sv */
module icr_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [4*WORD_BITS:0]   num,
  input  logic [3*WORD_BITS-1:0] den,
  output logic [WORD_BITS:0]     quo
);
  localparam int W     = WORD_BITS;
  localparam int NW    = 4 * W + 1;
  localparam int DNW   = 3 * W;
  localparam int QB    = W + 1;
  localparam int STEPS = W + 1;
  localparam logic [QB:0] CAP = {1'b0, 1'b1, {W{1'b0}}};

  logic [NW-1:0]  rem [STEPS+1];
  logic [DNW-1:0] dv  [STEPS+1];
  logic [QB-1:0]  qa  [STEPS+1];
  logic           ov  [STEPS+1];

  logic [NW:0]    rem2;
  logic [NW:0]    den2;
  logic           rnd;
  logic [QB:0]    qsum;

  // A quotient of 2^(W+1) or more always clamps, so only W+1 bits are developed.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      qa[0]  <= '0;
      ov[0]  <= (num >= {den, {QB{1'b0}}});
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    localparam int B = STEPS - k;
    logic [NW-1:0] sh;
    logic          ge;
    assign sh = {{(NW-DNW){1'b0}}, dv[k-1]} << B;
    assign ge = (rem[k-1] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? (rem[k-1] - sh) : rem[k-1];
        qa[k]  <= ge ? (qa[k-1] | (QB'(1) << B)) : qa[k-1];
        dv[k]  <= dv[k-1];
        ov[k]  <= ov[k-1];
      end
    end
  end

  // Round half away from zero on the final remainder.
  assign rem2 = {rem[STEPS], 1'b0};
  assign den2 = {{(NW+1-DNW){1'b0}}, dv[STEPS]};
  assign rnd  = (rem2 >= den2);
  assign qsum = {1'b0, qa[STEPS]} + {{QB{1'b0}}, rnd};

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= (ov[STEPS] || (qsum > CAP)) ? CAP[QB-1:0] : qsum[QB-1:0];
    end
  end

endmodule

/* hw/rtl/impulse_collision_resolver.sv */
// Elastic impulse resolver for one pair of bodies per item. The input item carries both
// velocities, the position difference first minus second and both inverse masses; the
// result gives both new velocities, saturated to the word range, and a status (impulse
// applied, separating, or degenerate when the positions coincide or both masses are
// infinite). The velocity changes are computed exactly from the raw integers and rounded to
// nearest, ties away from zero. The block is fully pipelined: a new item is taken every
// cycle while the output is not stalled. The divider develops one quotient bit per stage;
// the products are cut into word-wide partial products on their own stages. A stall at
// the output freezes the whole pipeline.
module impulse_collision_resolver #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // first_vel_x/y/z, second_vel_x/y/z, delta_pos_x/y/z, first_inv_mass, second_inv_mass
  input  logic [((11*WORD_BITS+5)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // new_first_vel_x/y/z, new_second_vel_x/y/z, outcome
  output logic [((6*WORD_BITS+9)/8)*8-1:0]    m_tdata
);
  import icr_pkg::*;

  localparam int W       = WORD_BITS;
  localparam int MW      = W - 1;
  localparam int PW      = 2 * W + 1;
  localparam int DW      = 2 * W;
  localparam int QW      = 2 * W + 1;
  localparam int NW      = 4 * W + 1;
  localparam int DNW     = 3 * W;
  localparam int VB      = 6 * W + 3;
  localparam int SBW     = VB + OUTCOME_BITS;
  localparam int DIV_LAT = W + 3;
  localparam int OUT_TW  = ((6 * W + 9) / 8) * 8;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: unpack, relative velocity and magnitudes.
  logic [W:0]     arv_next [3];
  logic [W-1:0]   ad_next  [3];
  logic [2:0]     ng_next;
  logic [VB-1:0]  sb_next;
  logic [MW-1:0]  m1_next, m2_next;

  always_comb begin
    logic signed [W-1:0] v1, v2, d;
    logic signed [W:0]   rv;
    sb_next = '0;
    for (int i = 0; i < 3; i++) begin
      v1 = s_tdata[i*W +: W];
      v2 = s_tdata[(3+i)*W +: W];
      d  = s_tdata[(6+i)*W +: W];
      rv = {v1[W-1], v1} - {v2[W-1], v2};
      arv_next[i] = rv[W] ? -rv : rv;
      ad_next[i]  = d[W-1] ? -d : d;
      ng_next[i]  = rv[W] ^ d[W-1];
      sb_next[i*W +: W]     = v1;
      sb_next[(3+i)*W +: W] = v2;
      sb_next[6*W+i]        = d[W-1];
    end
    m1_next = s_tdata[9*W +: MW];
    m2_next = s_tdata[9*W+MW +: MW];
  end

  logic           s1_valid;
  logic [W:0]     s1_arv [3];
  logic [W-1:0]   s1_ad  [3];
  logic [2:0]     s1_ng;
  logic [VB-1:0]  s1_sb;
  logic [MW-1:0]  s1_m1, s1_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_arv <= arv_next;
      s1_ad  <= ad_next;
      s1_ng  <= ng_next;
      s1_sb  <= sb_next;
      s1_m1  <= m1_next;
      s1_m2  <= m2_next;
    end
  end

  // Stage 2: per-axis products.
  logic           s2_valid;
  logic [PW-1:0]  s2_pr [3];
  logic [DW-1:0]  s2_sq [3];
  logic [W-1:0]   s2_ad [3];
  logic [2:0]     s2_ng;
  logic [VB-1:0]  s2_sb;
  logic [MW-1:0]  s2_m1, s2_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_pr[i] <= s1_arv[i] * s1_ad[i];
        s2_sq[i] <= s1_ad[i] * s1_ad[i];
      end
      s2_ad <= s1_ad;
      s2_ng <= s1_ng;
      s2_sb <= s1_sb;
      s2_m1 <= s1_m1;
      s2_m2 <= s1_m2;
    end
  end

  // Stage 3: dot products, split by sign so that they stay unsigned.
  logic [PW-1:0]  pos_next, neg_next;
  logic [DW-1:0]  dd_next;

  always_comb begin
    pos_next = '0;
    neg_next = '0;
    dd_next  = '0;
    for (int i = 0; i < 3; i++) begin
      if (s2_ng[i]) begin
        neg_next = neg_next + s2_pr[i];
      end else begin
        pos_next = pos_next + s2_pr[i];
      end
      dd_next = dd_next + s2_sq[i];
    end
  end

  logic           s3_valid;
  logic [PW-1:0]  s3_pos, s3_neg;
  logic [DW-1:0]  s3_dd;
  logic [W-1:0]   s3_ad [3];
  logic [VB-1:0]  s3_sb;
  logic [MW-1:0]  s3_m1, s3_m2;
  logic [W-1:0]   s3_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pos <= pos_next;
      s3_neg <= neg_next;
      s3_dd  <= dd_next;
      s3_ad  <= s2_ad;
      s3_sb  <= s2_sb;
      s3_m1  <= s2_m1;
      s3_m2  <= s2_m2;
      s3_ms  <= {1'b0, s2_m1} + {1'b0, s2_m2};
    end
  end

  // Stage 4: classify the pair and form the approach speed term.
  outcome_t       oc_next;

  always_comb begin
    if ((s3_dd == '0) || (s3_ms == '0)) begin
      oc_next = OC_DEGENERATE;
    end else if (s3_pos > s3_neg) begin
      oc_next = OC_SEPARATING;
    end else begin
      oc_next = OC_APPLIED;
    end
  end

  logic           s4_valid;
  logic [QW-1:0]  s4_q;
  logic [DW-1:0]  s4_dd;
  logic [W-1:0]   s4_ms;
  logic [MW-1:0]  s4_m [2];
  logic [W-1:0]   s4_ad [3];
  logic [SBW-1:0] s4_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q    <= s3_neg - s3_pos;
      s4_dd   <= s3_dd;
      s4_ms   <= s3_ms;
      s4_m[0] <= s3_m1;
      s4_m[1] <= s3_m2;
      s4_ad   <= s3_ad;
      s4_sb   <= {oc_next, s3_sb};
    end
  end

  // Stage 5: partial products of q times each mass and of the denominator.
  logic           s5_valid;
  logic [DW-1:0]  s5_qlo [2];
  logic [DW-1:0]  s5_qhi [2];
  logic [DW-1:0]  s5_dlo, s5_dhi;
  logic [W-1:0]   s5_ad [3];
  logic [SBW-1:0] s5_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        s5_qlo[k] <= s4_q[W-1:0] * s4_m[k];
        s5_qhi[k] <= s4_q[QW-1:W] * s4_m[k];
      end
      s5_dlo <= s4_dd[W-1:0] * s4_ms;
      s5_dhi <= s4_dd[DW-1:W] * s4_ms;
      s5_ad  <= s4_ad;
      s5_sb  <= s4_sb;
    end
  end

  // Stage 6: combine the partial products.
  logic           s6_valid;
  logic [DNW-1:0] s6_qm [2];
  logic [DNW-1:0] s6_den;
  logic [W-1:0]   s6_ad [3];
  logic [SBW-1:0] s6_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        s6_qm[k] <= DNW'(s5_qlo[k]) + {s5_qhi[k][DW-1:0], {W{1'b0}}};
      end
      s6_den <= DNW'(s5_dlo) + {s5_dhi, {W{1'b0}}};
      s6_ad  <= s5_ad;
      s6_sb  <= s5_sb;
    end
  end

  // Stage 7: word-wide chunks of q*m times each axis magnitude.
  logic           s7_valid;
  logic [DW-1:0]  s7_pp [2][3][3];
  logic [DNW-1:0] s7_den;
  logic [SBW-1:0] s7_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            s7_pp[k][i][j] <= s6_qm[k][j*W +: W] * s6_ad[i];
          end
        end
      end
      s7_den <= s6_den;
      s7_sb  <= s6_sb;
    end
  end

  // Stage 8: numerators, doubled for the restitution of one.
  logic [NW-1:0]  n_next [2][3];

  always_comb begin
    logic [NW-1:0] acc;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        acc = NW'(s7_pp[k][i][0])
            + NW'({s7_pp[k][i][1], {W{1'b0}}})
            + NW'({s7_pp[k][i][2], {(2*W){1'b0}}});
        n_next[k][i] = acc << 1;
      end
    end
  end

  logic           s8_valid;
  logic [NW-1:0]  s8_n [2][3];
  logic [DNW-1:0] s8_den;
  logic [SBW-1:0] s8_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_n   <= n_next;
      s8_den <= s7_den;
      s8_sb  <= s7_sb;
    end
  end

  // Dividers, one per body and axis, with the side data delayed alongside.
  logic [W:0] chg [2][3];

  for (genvar k = 0; k < 2; k++) begin : g_body
    for (genvar i = 0; i < 3; i++) begin : g_axis
      icr_div #(
        .WORD_BITS (WORD_BITS)
      ) u_div (
        .clk (clk),
        .en  (en),
        .num (s8_n[k][i]),
        .den (s8_den),
        .quo (chg[k][i])
      );
    end
  end

  logic [DIV_LAT-1:0] dl_valid;
  logic [SBW-1:0]     dl_sb [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid <= '0;
    end else if (en) begin
      dl_valid <= {dl_valid[DIV_LAT-2:0], s8_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_sb[0] <= s8_sb;
      for (int j = 1; j < DIV_LAT; j++) begin
        dl_sb[j] <= dl_sb[j-1];
      end
    end
  end

  // Output stage: signed update and saturation.
  function automatic logic [W-1:0] sat(input logic signed [W+2:0] x);
    logic signed [W+2:0] hi, lo;
    hi = (W+3)'(signed'({1'b0, {(W-1){1'b1}}}));
    lo = -hi - (W+3)'(1);
    if (x > hi) begin
      return hi[W-1:0];
    end else if (x < lo) begin
      return lo[W-1:0];
    end
    return x[W-1:0];
  endfunction

  logic [SBW-1:0]    fin_sb;
  logic [OUT_TW-1:0] data_next;
  logic [OUT_TW-1:0] data;

  assign fin_sb = dl_sb[DIV_LAT-1];

  always_comb begin
    logic signed [W-1:0] v1, v2;
    logic signed [W+1:0] c1, c2;
    logic signed [W+2:0] r1, r2;
    logic                apply;
    data_next = '0;
    apply = (fin_sb[VB +: OUTCOME_BITS] == OC_APPLIED);
    for (int i = 0; i < 3; i++) begin
      v1 = fin_sb[i*W +: W];
      v2 = fin_sb[(3+i)*W +: W];
      c1 = {1'b0, chg[0][i]};
      c2 = {1'b0, chg[1][i]};
      if (fin_sb[6*W+i]) begin
        c1 = -c1;
        c2 = -c2;
      end
      r1 = (W+3)'(v1) + (W+3)'(c1);
      r2 = (W+3)'(v2) - (W+3)'(c2);
      data_next[i*W +: W]     = apply ? sat(r1) : v1;
      data_next[(3+i)*W +: W] = apply ? sat(r2) : v2;
    end
    data_next[6*W +: OUTCOME_BITS] = fin_sb[VB +: OUTCOME_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dl_valid[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

  assign m_tdata = data;

endmodule

/* hw/rtl/icr_checker.sv */
module icr_checker #(
  parameter int WORD_BITS = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [((11*WORD_BITS+5)/8)*8-1:0]   s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((6*WORD_BITS+9)/8)*8-1:0]    m_tdata
);
  import icr_pkg::*;

  // The pipeline is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item present after reset");

  // A free output stage always lets the next item in.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input refused although output is free");

  // A stalled output freezes the whole pipeline, input included.
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output is stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result item changed");

  // A valid result never carries a status code outside the three defined outcomes.
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6*WORD_BITS +: OUTCOME_BITS] == OC_APPLIED
               || m_tdata[6*WORD_BITS +: OUTCOME_BITS] == OC_SEPARATING
               || m_tdata[6*WORD_BITS +: OUTCOME_BITS] == OC_DEGENERATE))
    else $error("bad status code");

endmodule

bind impulse_collision_resolver icr_checker #(
  .WORD_BITS (WORD_BITS)
) u_icr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/impulse_collision_resolver_tb.sv */
module impulse_collision_resolver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icr_pkg::*;

  localparam int W = 32;
  localparam int IN_BITS = ((11*W+5)/8)*8;
  localparam int OUT_BITS = ((6*W+9)/8)*8;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = W + 40;
  localparam longint SMAX = (64'sd1 <<< (W-1)) - 64'sd1;
  localparam longint SMIN = -SMAX - 64'sd1;

  typedef struct {
    logic signed [W-1:0] va[3];
    logic signed [W-1:0] vb[3];
    logic signed [W-1:0] dp[3];
    logic [W-2:0] ma;
    logic [W-2:0] mb;
  } body_pair_t;

  typedef struct {
    logic [W-1:0] na[3];
    logic [W-1:0] nb[3];
    outcome_t oc;
  } resolved_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  resolved_t pending_q[$];
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int outcome_seen[3] = '{0, 0, 0};
  int idle_cycles = 0;

  impulse_collision_resolver #(.WORD_BITS(W)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Exact rational impulse on the raw integers; the Q scale cancels out.
  function automatic resolved_t resolve_pair(body_pair_t p);
    resolved_t r;
    longint v1[3], v2[3], d[3];
    longint rv, c1, c2;
    logic [255:0] ad[3];
    logic [255:0] dd, pos, neg, q, msum, num, den, c, cap;
    dd = '0; pos = '0; neg = '0;
    cap = 256'd1 << W;
    for (int i = 0; i < 3; i++) begin
      v1[i] = p.va[i];
      v2[i] = p.vb[i];
      d[i] = p.dp[i];
      rv = v1[i] - v2[i];
      ad[i] = 256'((d[i] < 0) ? -d[i] : d[i]);
      dd = dd + ad[i] * ad[i];
      if ((rv < 0) != (d[i] < 0))
        neg = neg + 256'((rv < 0) ? -rv : rv) * ad[i];
      else
        pos = pos + 256'((rv < 0) ? -rv : rv) * ad[i];
    end
    msum = 256'(p.ma) + 256'(p.mb);
    if (dd == 0 || msum == 0) begin
      r.oc = OC_DEGENERATE;
    end else if (pos > neg) begin
      r.oc = OC_SEPARATING;
    end else begin
      r.oc = OC_APPLIED;
      q = neg - pos;
      den = msum * dd;
      for (int i = 0; i < 3; i++) begin
        if (d[i] != 0) begin
          num = 2 * q * ad[i] * 256'(p.ma);
          c = (2 * num + den) / (2 * den);
          if (c > cap) c = cap;
          c1 = longint'(c[W:0]);
          num = 2 * q * ad[i] * 256'(p.mb);
          c = (2 * num + den) / (2 * den);
          if (c > cap) c = cap;
          c2 = longint'(c[W:0]);
          if (d[i] < 0) begin
            c1 = -c1;
            c2 = -c2;
          end
          v1[i] = v1[i] + c1;
          v2[i] = v2[i] - c2;
          if (v1[i] > SMAX) v1[i] = SMAX;
          if (v1[i] < SMIN) v1[i] = SMIN;
          if (v2[i] > SMAX) v2[i] = SMAX;
          if (v2[i] < SMIN) v2[i] = SMIN;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.na[i] = v1[i][W-1:0];
      r.nb[i] = v2[i][W-1:0];
    end
    return r;
  endfunction

  task automatic send_pair(body_pair_t p);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, p.mb, p.ma, p.dp[2], p.dp[1], p.dp[0],
                p.vb[2], p.vb[1], p.vb[0], p.va[2], p.va[1], p.va[0]};
    do @(posedge clk); while (!s_tready);
    pending_q.push_back(resolve_pair(p));
    pairs_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    resolved_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result arrived with nothing outstanding");
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[W*i +: W] !== exp_r.na[i]) begin
            $error("new_first_vel[%0d]: expected %h, got %h", i, exp_r.na[i],
                   m_tdata[W*i +: W]);
            errors++;
          end
          if (m_tdata[W*(3+i) +: W] !== exp_r.nb[i]) begin
            $error("new_second_vel[%0d]: expected %h, got %h", i, exp_r.nb[i],
                   m_tdata[W*(3+i) +: W]);
            errors++;
          end
        end
        if (m_tdata[6*W +: 2] !== exp_r.oc) begin
          $error("outcome: expected %0d, got %0d", exp_r.oc, m_tdata[6*W +: 2]);
          errors++;
        end
        outcome_seen[exp_r.oc]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("impulse_collision_resolver test failed");
        $finish;
      end
    end
  end

  function automatic logic signed [W-1:0] pick_coord(int style);
    case (style)
      0: return $urandom;
      1: return $signed(W'($urandom_range(8191))) - 4096;
      2: return $signed(W'($urandom_range(1 << 22))) - (1 << 21);
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  function automatic logic [W-2:0] pick_mass();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return (W-1)'($urandom);
      default: return (W-1)'($urandom_range(1 << 18));
    endcase
  endfunction

  function automatic body_pair_t make_pair(int style);
    body_pair_t p;
    for (int i = 0; i < 3; i++) begin
      p.va[i] = pick_coord(style);
      p.vb[i] = pick_coord(style);
      p.dp[i] = pick_coord(style);
    end
    p.ma = pick_mass();
    p.mb = pick_mass();
    return p;
  endfunction

  function automatic body_pair_t plain_pair(longint v1x, longint v2x, longint dx,
                                            longint m1, longint m2);
    body_pair_t p;
    for (int i = 0; i < 3; i++) begin
      p.va[i] = '0;
      p.vb[i] = '0;
      p.dp[i] = '0;
    end
    p.va[0] = W'(v1x);
    p.vb[0] = W'(v2x);
    p.dp[0] = W'(dx);
    p.ma = (W-1)'(m1);
    p.mb = (W-1)'(m2);
    return p;
  endfunction

  task automatic test_directed();
    body_pair_t p;
    // Pair moving apart along x, equal masses: velocities stay.
    send_pair(plain_pair(65536, -65536, 65536, 65536, 65536));
    // Same pair approaching head-on: velocities swap.
    send_pair(plain_pair(-65536, 65536, 65536, 65536, 65536));
    // Coincident positions.
    send_pair(plain_pair(65536, -65536, 0, 65536, 65536));
    // Both bodies immovable.
    send_pair(plain_pair(65536, -65536, 65536, 0, 0));
    // One body immovable, on each side.
    send_pair(plain_pair(65536, -65536, 65536, 0, 65536));
    send_pair(plain_pair(65536, -65536, 65536, 65536, 0));
    // Tangential contact: relative velocity along y, normal along x.
    p = plain_pair(0, 0, 65536, 65536, 65536);
    p.va[1] = 32'sd131072;
    send_pair(p);
    // Saturation at both ends of the word range.
    send_pair(plain_pair(SMIN, SMAX, 1, SMAX, SMAX));
    send_pair(plain_pair(SMAX, SMIN, SMIN, SMAX, 1));
    send_pair(plain_pair(SMIN, SMAX, SMAX, 1, SMAX));
    // Diagonal normal with all components and odd values for rounding.
    p = plain_pair(3, -5, 7, 3, 5);
    p.va[1] = -11; p.vb[1] = 13; p.dp[1] = -1;
    p.va[2] = 1; p.vb[2] = -1; p.dp[2] = 2;
    send_pair(p);
    p.dp[0] = W'(SMIN); p.dp[1] = W'(SMAX); p.dp[2] = W'(SMIN);
    send_pair(p);
    for (int k = 0; k < 6; k++) send_pair(make_pair(3));
    for (int k = 0; k < 4; k++) send_pair(make_pair(0));
  endtask

  task automatic test_random_phase(int n, int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (int k = 0; k < n; k++)
      send_pair(make_pair($urandom_range(9) < 3 ? 0 : ($urandom_range(9) < 6 ? 1 : 2)));
    go_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    go_quiet();
    test_random_phase(250, 0, 0);
    test_random_phase(250, 82, 0);
    test_random_phase(250, 0, 82);
    test_random_phase(250, 12, 12);
    snk_stall_pct = 0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d body pairs and checked %0d results under four idling patterns.",
             pairs_sent, results_seen);
    $display("Outcomes: %0d applied, %0d separating, %0d degenerate.",
             outcome_seen[0], outcome_seen[1], outcome_seen[2]);
    if (errors == 0 && pending_q.size() == 0)
      $display("impulse_collision_resolver test passed");
    else
      $display("impulse_collision_resolver test failed");
    $finish;
  end

endmodule
